// ===== hdl/sdmw_pkg.sv =====
// ---------------------------------------------------------------------------
// sdmw_pkg
// Shared types and constants for the weighted sparse distributed memory.
// ---------------------------------------------------------------------------
package sdmw_pkg;

   localparam int unsigned LOCATIONS_DEF    = 1024;
   localparam int unsigned ADDR_BITS_DEF    = 64;
   localparam int unsigned DATA_BITS_DEF    = 64;
   localparam int unsigned COUNTER_BITS_DEF = 32;

   localparam int unsigned OPCODE_W  = 2;
   localparam int unsigned LOC_IDX_W = 10;
   localparam int unsigned FIELD_W   = 64;
   localparam int unsigned ACTIVE_W  = 11;
   localparam int unsigned STEP_W    = 16;
   localparam int unsigned LIU_W     = 11;
   localparam int unsigned WEIGHT_W  = 17;
   localparam int unsigned SUM_W     = 64;

   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

   localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;
   localparam logic [LIU_W-1:0]  LIU_RESET  = 11'd1024;

   localparam logic [OPCODE_W-1:0] OP_LOAD     = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_STORE    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RETRIEVE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_STEP   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCATIONS_IN_USE = 1'b1;

   typedef struct packed {
      logic valid;
      logic active;
   } sdmw_wstat_type;

   typedef struct packed {
      logic clear;
      logic accumulate;
   } sdmw_lane_ctl_type;

endpackage

// ===== hdl/sdmw_if.sv =====
// ---------------------------------------------------------------------------
// sdmw_if
// Request and response channel interfaces with valid/ready handshake.
// ---------------------------------------------------------------------------
interface sdmw_req_if
   import sdmw_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [LOC_IDX_W-1:0] location_index;
   logic [FIELD_W-1:0]   address_pattern;
   logic [FIELD_W-1:0]   data_pattern;
   logic                 nearest_relative;

   modport source (output valid, opcode, location_index, address_pattern, data_pattern,
                   nearest_relative, input ready);
   modport sink   (input valid, opcode, location_index, address_pattern, data_pattern,
                   nearest_relative, output ready);
endinterface

interface sdmw_rsp_if
   import sdmw_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [FIELD_W-1:0]  data_out;
   logic [ACTIVE_W-1:0] active_count;

   modport source (output valid, data_out, active_count, input ready);
   modport sink   (input valid, data_out, active_count, output ready);
endinterface

// ===== hdl/sparse_distributed_memory_weighted.sv =====
// ---------------------------------------------------------------------------
// sparse_distributed_memory_weighted
// Kanerva-style sparse distributed memory with graded location weights.
// ---------------------------------------------------------------------------
// A load goes from acceptance straight to FINISH and the response. A store or
// retrieve scans the location rows through the weight and lane pipelines; in
// nearest-relative mode a distance pass over the same rows runs first.
// Throughput: one transaction at a time; the scan reads one location row per
// cycle from the address and counter memories. Reset restores the CSR registers
// and control; the memories hold undefined contents until loaded.
module sparse_distributed_memory_weighted
   import sdmw_pkg::*;
#(
   parameter int unsigned LOCATIONS    = LOCATIONS_DEF,
   parameter int unsigned ADDR_BITS    = ADDR_BITS_DEF,
   parameter int unsigned DATA_BITS    = DATA_BITS_DEF,
   parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   sdmw_req_if.sink              req_if,
   sdmw_rsp_if.source            rsp_if,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);
   localparam int unsigned LOC_W   = (LOCATIONS > 1) ? $clog2(LOCATIONS) : 1;
   localparam int unsigned DIST_W  = $clog2(ADDR_BITS + 1);
   localparam int unsigned ROW_W   = DATA_BITS * COUNTER_BITS;
   localparam int unsigned LOC_CAP = (LOCATIONS > 2047) ? 2047 : LOCATIONS;

   typedef enum logic [1:0] {
      IDLE,
      MIN_SCAN,
      SCAN,
      FINISH
   } state_type;

   // Control and operation registers.
   state_type           state_ff;
   logic [OPCODE_W-1:0] op_ff;
   logic [ADDR_BITS-1:0] key_ff;
   logic [DATA_BITS-1:0] data_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [LIU_W-1:0]    liu_ff;
   logic [LIU_W-1:0]    j_ff;
   logic [DIST_W-1:0]   base_ff;
   logic [DIST_W-1:0]   best_ff;
   logic [ACTIVE_W-1:0] active_cnt_ff;

   // Scan pipeline bookkeeping: row tags follow the memory reads.
   logic                p0_valid_ff;
   logic [LOC_W-1:0]    p0_row_ff;
   logic [LOC_W-1:0]    p1_row_ff;
   logic [LOC_W-1:0]    p2_row_ff;
   logic                p3_valid_ff;

   // Response output register.
   logic                rsp_valid_ff;
   logic [FIELD_W-1:0]  rsp_data_ff;
   logic [ACTIVE_W-1:0] rsp_active_ff;

   logic                accept;
   logic [LIU_W-1:0]    scan_n;
   logic                issue;
   logic                min_done;
   logic                scan_done;
   logic                load_hit;

   logic [ADDR_BITS-1:0] loc_addr;
   logic [ROW_W-1:0]     cnt_row;
   logic [ROW_W-1:0]     cnt_row_new;
   logic                 cnt_we;
   logic [LOC_W-1:0]     cnt_wr_addr;
   logic [ROW_W-1:0]     cnt_wr_data;

   logic [DIST_W-1:0]   distance;
   logic                dist_valid;
   logic [WEIGHT_W-1:0] weight;
   sdmw_wstat_type      stat;
   sdmw_lane_ctl_type   lane_ctl;
   logic [DATA_BITS-1:0] sum_bits;
   logic                 active_hit;

   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == IDLE);

   // Scan count is the register value clipped to the memory depth.
   assign scan_n = (liu_ff > LIU_W'(LOC_CAP)) ? LIU_W'(LOC_CAP) : liu_ff;

   assign issue = ((state_ff == MIN_SCAN) || (state_ff == SCAN)) && (j_ff != scan_n);

   assign min_done  = (j_ff == scan_n) && !p0_valid_ff && !dist_valid && !stat.valid;
   assign scan_done = min_done && !p3_valid_ff;

   // A load with an index past the memory depth changes nothing.
   assign load_hit = accept && (req_if.opcode == OP_LOAD)
                     && (32'(req_if.location_index) < LOCATIONS);

   assign active_hit = (state_ff == SCAN) && stat.valid && stat.active;

   // The counter memory write port serves both a load (row clear) and the
   // store write-back, addressed by the row tag carried through p0/p1/p2_row_ff.
   always_comb begin
      if (load_hit) begin
         cnt_we      = 1'b1;
         cnt_wr_addr = LOC_W'(req_if.location_index);
         cnt_wr_data = '0;
      end else begin
         cnt_we      = active_hit && (op_ff == OP_STORE);
         cnt_wr_addr = p2_row_ff;
         cnt_wr_data = cnt_row_new;
      end
   end

   sdmw_ram #(
      .WIDTH (ADDR_BITS),
      .DEPTH (LOCATIONS)
   ) u_addr_ram (
      .clock   (clock),
      .wr_en   (load_hit),
      .wr_addr (LOC_W'(req_if.location_index)),
      .wr_data (req_if.address_pattern[ADDR_BITS-1:0]),
      .rd_addr (LOC_W'(j_ff)),
      .rd_data (loc_addr)
   );

   sdmw_ram #(
      .WIDTH (ROW_W),
      .DEPTH (LOCATIONS)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (p1_row_ff),
      .rd_data (cnt_row)
   );

   sdmw_weight #(
      .ADDR_BITS (ADDR_BITS)
   ) u_weight (
      .clock      (clock),
      .reset      (reset),
      .valid_in   (p0_valid_ff),
      .loc_addr   (loc_addr),
      .key        (key_ff),
      .base       (base_ff),
      .step       (step_ff),
      .distance   (distance),
      .dist_valid (dist_valid),
      .weight     (weight),
      .stat       (stat)
   );

   // Sums are cleared when a transaction is taken; only active locations of a
   // retrieve scan feed the accumulators.
   assign lane_ctl.clear      = accept;
   assign lane_ctl.accumulate = active_hit && (op_ff == OP_RETRIEVE);

   for (genvar i = 0; i < DATA_BITS; i++) begin : g_lane
      sdmw_lane #(
         .COUNTER_BITS (COUNTER_BITS)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .ctl         (lane_ctl),
         .counter_in  (cnt_row[i*COUNTER_BITS +: COUNTER_BITS]),
         .weight      (weight),
         .data_bit    (data_ff[i]),
         .counter_out (cnt_row_new[i*COUNTER_BITS +: COUNTER_BITS]),
         .sum_nonneg  (sum_bits[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= STEP_RESET;
         liu_ff       <= LIU_RESET;
         p0_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_THRESHOLD_STEP:   step_ff <= csr_write_data[STEP_W-1:0];
               CSR_LOCATIONS_IN_USE: liu_ff  <= csr_write_data[LIU_W-1:0];
               default: ;
            endcase
         end

         p0_valid_ff <= issue;
         p3_valid_ff <= lane_ctl.accumulate;

         // A taken response empties the output register, unless FINISH
         // refills it in the same cycle.
         if (rsp_if.ready && (state_ff != FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  op_ff         <= req_if.opcode;
                  key_ff        <= req_if.address_pattern[ADDR_BITS-1:0];
                  data_ff       <= req_if.data_pattern[DATA_BITS-1:0];
                  j_ff          <= '0;
                  base_ff       <= '0;
                  best_ff       <= DIST_W'(ADDR_BITS);
                  active_cnt_ff <= '0;
                  if (req_if.opcode == OP_STORE || req_if.opcode == OP_RETRIEVE) begin
                     state_ff <= req_if.nearest_relative ? MIN_SCAN : SCAN;
                  end else begin
                     state_ff <= FINISH;
                  end
               end
            end
            MIN_SCAN: begin
               if (issue) begin
                  j_ff <= j_ff + 1'b1;
               end
               if (dist_valid && (distance < best_ff)) begin
                  best_ff <= distance;
               end
               if (min_done) begin
                  base_ff  <= best_ff;
                  j_ff     <= '0;
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               if (issue) begin
                  j_ff <= j_ff + 1'b1;
               end
               if (active_hit) begin
                  active_cnt_ff <= active_cnt_ff + 1'b1;
               end
               if (scan_done) begin
                  state_ff <= FINISH;
               end
            end
            FINISH: begin
               // Wait for the output register to free up before handing over.
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_data_ff   <= (op_ff == OP_RETRIEVE) ? FIELD_W'(sum_bits) : '0;
                  rsp_active_ff <= active_cnt_ff;
                  state_ff      <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end

      p0_row_ff <= LOC_W'(j_ff);
      p1_row_ff <= p0_row_ff;
      p2_row_ff <= p1_row_ff;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.data_out     = rsp_data_ff;
   assign rsp_if.active_count = rsp_active_ff;
endmodule

// ===== hdl/sdmw_ram.sv =====
// ---------------------------------------------------------------------------
// sdmw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module sdmw_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/sdmw_weight.sv =====
// ---------------------------------------------------------------------------
// sdmw_weight
// Two-stage distance and weight pipeline for one location per cycle.
// ---------------------------------------------------------------------------
module sdmw_weight
   import sdmw_pkg::*;
#(
   parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             valid_in,
   input  logic [ADDR_BITS-1:0]             loc_addr,
   input  logic [ADDR_BITS-1:0]             key,
   input  logic [$clog2(ADDR_BITS+1)-1:0]   base,
   input  logic [STEP_W-1:0]                step,
   output logic [$clog2(ADDR_BITS+1)-1:0]   distance,
   output logic                             dist_valid,
   output logic [WEIGHT_W-1:0]              weight,
   output sdmw_wstat_type                   stat
);
   localparam int unsigned DIST_W = $clog2(ADDR_BITS + 1);
   localparam int unsigned PROD_W = STEP_W + DIST_W;
   localparam int unsigned WF_W   = PROD_W + 2;

   function automatic logic [6:0] popcount(input logic [63:0] v);
      logic [3:0] cnt [8];
      logic [6:0] s;
      for (int k = 0; k < 8; k++) begin
         cnt[k] = '0;
         for (int m = 0; m < 8; m++) begin
            cnt[k] = cnt[k] + 4'(v[8*k+m]);
         end
      end
      s = '0;
      for (int k = 0; k < 8; k++) begin
         s = s + 7'(cnt[k]);
      end
      return s;
   endfunction

   logic [DIST_W-1:0]   dist_ff;
   logic                dist_valid_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   sdmw_wstat_type      stat_ff;

   logic [DIST_W-1:0] diff;
   logic [PROD_W-1:0] prod;
   logic [WF_W-1:0]   wfull;

   always_comb begin
      diff  = dist_ff - base;
      prod  = PROD_W'(step) * PROD_W'(diff);
      wfull = WF_W'(ONE_Q16) - WF_W'(prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_valid_ff <= 1'b0;
         stat_ff       <= '0;
      end else begin
         dist_valid_ff  <= valid_in;
         stat_ff.valid  <= dist_valid_ff;
         stat_ff.active <= !wfull[WF_W-1] && (wfull != '0);
      end
      dist_ff   <= DIST_W'(popcount(64'(loc_addr ^ key)));
      weight_ff <= wfull[WEIGHT_W-1:0];
   end

   assign distance   = dist_ff;
   assign dist_valid = dist_valid_ff;
   assign weight     = weight_ff;
   assign stat       = stat_ff;
endmodule

// ===== hdl/sdmw_lane.sv =====
// ---------------------------------------------------------------------------
// sdmw_lane
// One data bit: saturating counter update and weighted retrieve sum.
// ---------------------------------------------------------------------------
module sdmw_lane
   import sdmw_pkg::*;
#(
   parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sdmw_lane_ctl_type       ctl,
   input  logic [COUNTER_BITS-1:0] counter_in,
   input  logic [WEIGHT_W-1:0]     weight,
   input  logic                    data_bit,
   output logic [COUNTER_BITS-1:0] counter_out,
   output logic                    sum_nonneg
);
   localparam int unsigned CX_W   = COUNTER_BITS + 2;
   localparam int unsigned PROD_W = COUNTER_BITS + WEIGHT_W;

   logic signed [COUNTER_BITS-1:0] cnt_s;
   logic signed [WEIGHT_W:0]       w_s;
   logic signed [CX_W-1:0]         cx;
   logic signed [CX_W-1:0]         wx;
   logic signed [CX_W-1:0]         upd;
   logic [2:0]                     upd_hi;
   logic signed [PROD_W-1:0]       prod;
   logic signed [SUM_W:0]          acc;

   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_valid_ff;
   logic signed [SUM_W-1:0]  sum_ff;

   always_comb begin
      cnt_s  = counter_in;
      w_s    = $signed({1'b0, weight});
      cx     = CX_W'(cnt_s);
      wx     = CX_W'(w_s);
      upd    = data_bit ? (cx + wx) : (cx - wx);
      upd_hi = upd[CX_W-1 -: 3];
      if (upd_hi == 3'b000 || upd_hi == 3'b111) begin
         counter_out = upd[COUNTER_BITS-1:0];
      end else if (upd[CX_W-1]) begin
         counter_out = {1'b1, {(COUNTER_BITS-1){1'b0}}};
      end else begin
         counter_out = {1'b0, {(COUNTER_BITS-1){1'b1}}};
      end
      prod = PROD_W'(cnt_s) * PROD_W'(w_s);
      acc  = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctl.accumulate;
      end
      prod_ff <= prod;
      if (ctl.clear) begin
         sum_ff <= '0;
      end else if (prod_valid_ff) begin
         if (acc[SUM_W] != acc[SUM_W-1]) begin
            sum_ff <= acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
         end else begin
            sum_ff <= acc[SUM_W-1:0];
         end
      end
   end

   assign sum_nonneg = !sum_ff[SUM_W-1];
endmodule
